// ===== hdl/gbs_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the greedy box suppression block
// no dependencies

package gbs_pkg;

   localparam int MaxKept    = 64;
   localparam int KeptAddrW  = $clog2(MaxKept);
   localparam int KeptCountW = $clog2(MaxKept + 1);
   localparam int QueueDepth = 2;
   localparam int IouResetValue = 29491;

   localparam int CoordW = 16;
   localparam int EdgeW  = 17;
   localparam int SizeW  = 15;
   localparam int AreaW  = 30;
   localparam int ThrW   = 16;
   localparam int UnionW = AreaW + 1;
   localparam int ProdW  = ThrW + UnionW;
   localparam int BoxNumW = 16;

   typedef struct packed {
      logic                     frame_start;
      logic signed [CoordW-1:0] left;
      logic signed [CoordW-1:0] top;
      logic signed [EdgeW-1:0]  right;
      logic signed [EdgeW-1:0]  bottom;
      logic [AreaW-1:0]         area;
   } box_type;

   typedef struct packed {
      logic signed [CoordW-1:0] left;
      logic signed [CoordW-1:0] top;
      logic signed [EdgeW-1:0]  right;
      logic signed [EdgeW-1:0]  bottom;
      logic [AreaW-1:0]         area;
   } entry_type;

   localparam int EntryW = $bits(entry_type);

   typedef struct packed {
      logic                  keep;
      logic [BoxNumW-1:0]    box_number;
      logic [KeptCountW-1:0] kept_total;
      logic                  store_overflow;
   } result_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } back_state_type;

endpackage

// ===== hdl/greedy_box_suppression_top.sv =====
`timescale 1ns / 1ps
// Greedy non-maximum suppression over boxes sorted by descending score. Each
// request gives exactly one response. For each box the back part takes it from
// the queue, issues one ram read a cycle for each stored box (up to 64), drains
// the overlap pipeline (read, span, intersection and union stages) and sees it
// empty, then makes the decision and store update once the output register is
// free. The front part and a two-deep queue take new requests while the back
// part works and a finished response waits in its output register.
// depends on gbs_pkg, gbs_front, gbs_queue, gbs_back

module greedy_box_suppression_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,   // iou_threshold
   input  logic        s_axis_tvalid,
   output logic        s_axis_tready,
   input  logic [63:0] s_axis_tdata,  // box_left, box_top, box_width, box_height, zero
   input  logic        s_axis_tuser,  // frame_start
   output logic        m_axis_tvalid,
   input  logic        m_axis_tready,
   output logic [31:0] m_axis_tdata   // keep, box_number, kept_total, store_overflow, zero
);

   logic [gbs_pkg::ThrW-1:0] thr_ff, thr_in;
   logic                     push_valid, push_ready, pop_valid, pop_ready;
   gbs_pkg::box_type         push_box, pop_box;
   gbs_pkg::result_type      result;

   assign thr_in = csr_wr_en ? csr_wr_data : thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= gbs_pkg::ThrW'(gbs_pkg::IouResetValue);
      end else begin
         thr_ff <= thr_in;
      end
   end

   gbs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (s_axis_tvalid),
      .req_ready   (s_axis_tready),
      .frame_start (s_axis_tuser),
      .box_left    ($signed(s_axis_tdata[15:0])),
      .box_top     ($signed(s_axis_tdata[31:16])),
      .box_width   (s_axis_tdata[46:32]),
      .box_height  (s_axis_tdata[61:47]),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_box    (push_box)
   );

   gbs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_box   (push_box),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_box    (pop_box)
   );

   gbs_back u_back (
      .clock         (clock),
      .reset         (reset),
      .iou_threshold (thr_ff),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .pop_box       (pop_box),
      .rsp_valid     (m_axis_tvalid),
      .rsp_ready     (m_axis_tready),
      .rsp_result    (result)
   );

   assign m_axis_tdata = {7'b0000000, result.store_overflow, result.kept_total,
                          result.box_number, result.keep};

endmodule

// ===== hdl/gbs_ram.sv =====
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
// no dependencies

module gbs_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/gbs_front.sv =====
`timescale 1ns / 1ps
// front part: takes a request, derives right and bottom edges and the area
// depends on gbs_pkg

module gbs_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        frame_start,
   input  logic signed [gbs_pkg::CoordW-1:0] box_left,
   input  logic signed [gbs_pkg::CoordW-1:0] box_top,
   input  logic [gbs_pkg::SizeW-1:0]   box_width,
   input  logic [gbs_pkg::SizeW-1:0]   box_height,
   output logic                        push_valid,
   input  logic                        push_ready,
   output gbs_pkg::box_type            push_box
);

   logic             valid_ff, valid_in;
   gbs_pkg::box_type box_ff, box_in;
   logic             take;

   assign req_ready = !valid_ff || push_ready;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
      box_in.frame_start = frame_start;
      box_in.left   = box_left;
      box_in.top    = box_top;
      box_in.right  = gbs_pkg::EdgeW'(box_left) + $signed({2'b00, box_width});
      box_in.bottom = gbs_pkg::EdgeW'(box_top) + $signed({2'b00, box_height});
      box_in.area   = gbs_pkg::AreaW'(box_width) * gbs_pkg::AreaW'(box_height);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         box_ff <= box_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_box   = box_ff;

endmodule

// ===== hdl/gbs_queue.sv =====
`timescale 1ns / 1ps
// short queue of prepared boxes between the front and back parts
// depends on gbs_pkg

module gbs_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  gbs_pkg::box_type push_box,
   output logic             pop_valid,
   input  logic             pop_ready,
   output gbs_pkg::box_type pop_box
);

   localparam int PtrW   = $clog2(gbs_pkg::QueueDepth);
   localparam int CountW = $clog2(gbs_pkg::QueueDepth + 1);

   gbs_pkg::box_type slots_ff [gbs_pkg::QueueDepth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = count_ff != CountW'(gbs_pkg::QueueDepth);
   assign pop_valid  = count_ff != '0;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_box    = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_box;
      end
   end

endmodule

// ===== hdl/gbs_back.sv =====
`timescale 1ns / 1ps
// back part: scans the kept store through an overlap pipeline, decides keep
// or drop, updates the store and holds the result; depends on gbs_pkg, gbs_ram

module gbs_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [gbs_pkg::ThrW-1:0]   iou_threshold,
   input  logic                       pop_valid,
   output logic                       pop_ready,
   input  gbs_pkg::box_type           pop_box,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output gbs_pkg::result_type        rsp_result
);

   localparam int AW = gbs_pkg::KeptAddrW;
   localparam int CW = gbs_pkg::KeptCountW;
   localparam int SpanW = gbs_pkg::SizeW;

   gbs_pkg::back_state_type state_ff, state_in;
   gbs_pkg::box_type        cur_ff, cur_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           idx_ff, idx_in;
   logic [gbs_pkg::BoxNumW-1:0] boxnum_ff, boxnum_in;
   logic                    hit_ff, hit_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   gbs_pkg::result_type     rsp_ff, rsp_in;

   logic                    v_rd_ff, v_sp_ff, v_in_ff, v_un_ff;
   logic [SpanW-1:0]        ix_ff, iy_ff;
   logic [gbs_pkg::AreaW-1:0] karea_sp_ff, karea_in_ff;
   logic [gbs_pkg::AreaW-1:0] inter_in_ff, inter_un_ff;
   logic [gbs_pkg::UnionW-1:0] union_ff;

   logic                    issue, finish_go, store_ok, keep;
   logic                    ram_wr;
   logic [gbs_pkg::EntryW-1:0] ram_rd_data;
   gbs_pkg::entry_type      rd_entry, wr_entry;

   logic signed [gbs_pkg::EdgeW-1:0] lo_x, hi_x, lo_y, hi_y;
   logic signed [gbs_pkg::EdgeW:0]   dx, dy;
   logic [SpanW-1:0]        ix_in, iy_in;
   logic [gbs_pkg::ProdW-1:0] lhs, rhs;

   assign issue     = state_ff == gbs_pkg::ST_SCAN && idx_ff != count_ff;
   assign finish_go = state_ff == gbs_pkg::ST_FINISH && (!rsp_valid_ff || rsp_ready);
   assign pop_ready = state_ff == gbs_pkg::ST_IDLE;
   assign keep      = !hit_ff;
   assign store_ok  = count_ff != CW'(gbs_pkg::MaxKept);
   assign ram_wr    = finish_go && keep && store_ok;

   assign wr_entry.left   = cur_ff.left;
   assign wr_entry.top    = cur_ff.top;
   assign wr_entry.right  = cur_ff.right;
   assign wr_entry.bottom = cur_ff.bottom;
   assign wr_entry.area   = cur_ff.area;
   assign rd_entry        = gbs_pkg::entry_type'(ram_rd_data);

   gbs_ram #(
      .Width (gbs_pkg::EntryW),
      .Depth (gbs_pkg::MaxKept)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_entry),
      .rd_en   (issue),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // overlap spans
   always_comb begin
      lo_x = (cur_ff.left > rd_entry.left) ? gbs_pkg::EdgeW'(cur_ff.left)
                                           : gbs_pkg::EdgeW'(rd_entry.left);
      hi_x = (cur_ff.right < rd_entry.right) ? cur_ff.right : rd_entry.right;
      lo_y = (cur_ff.top > rd_entry.top) ? gbs_pkg::EdgeW'(cur_ff.top)
                                         : gbs_pkg::EdgeW'(rd_entry.top);
      hi_y = (cur_ff.bottom < rd_entry.bottom) ? cur_ff.bottom : rd_entry.bottom;
      dx   = (gbs_pkg::EdgeW + 1)'(hi_x) - (gbs_pkg::EdgeW + 1)'(lo_x);
      dy   = (gbs_pkg::EdgeW + 1)'(hi_y) - (gbs_pkg::EdgeW + 1)'(lo_y);
      ix_in = (hi_x > lo_x) ? dx[SpanW-1:0] : '0;
      iy_in = (hi_y > lo_y) ? dy[SpanW-1:0] : '0;
   end

   assign lhs = {1'b0, inter_un_ff, 16'h0000};
   assign rhs = iou_threshold * union_ff;

   always_ff @(posedge clock) begin
      ix_ff       <= ix_in;
      iy_ff       <= iy_in;
      karea_sp_ff <= rd_entry.area;
      inter_in_ff <= ix_ff * iy_ff;
      karea_in_ff <= karea_sp_ff;
      union_ff    <= gbs_pkg::UnionW'(cur_ff.area) + gbs_pkg::UnionW'(karea_in_ff)
                     - gbs_pkg::UnionW'(inter_in_ff);
      inter_un_ff <= inter_in_ff;
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      boxnum_in    = boxnum_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (v_un_ff && lhs > rhs) begin
         hit_in = 1'b1;
      end
      unique case (state_ff)
         gbs_pkg::ST_IDLE: begin
            if (pop_valid) begin
               cur_in = pop_box;
               idx_in = '0;
               hit_in = 1'b0;
               if (pop_box.frame_start) begin
                  count_in  = '0;
                  boxnum_in = '0;
               end
               state_in = gbs_pkg::ST_SCAN;
            end
         end
         gbs_pkg::ST_SCAN: begin
            if (issue) begin
               idx_in = idx_ff + 1'b1;
            end else if (!(v_rd_ff || v_sp_ff || v_in_ff || v_un_ff)) begin
               state_in = gbs_pkg::ST_FINISH;
            end
         end
         gbs_pkg::ST_FINISH: begin
            if (finish_go) begin
               if (ram_wr) begin
                  count_in = count_ff + 1'b1;
               end
               rsp_valid_in          = 1'b1;
               rsp_in.keep           = keep;
               rsp_in.box_number     = boxnum_ff;
               rsp_in.kept_total     = ram_wr ? count_ff + 1'b1 : count_ff;
               rsp_in.store_overflow = keep && !store_ok;
               boxnum_in             = boxnum_ff + 1'b1;
               state_in              = gbs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gbs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gbs_pkg::ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         boxnum_ff    <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         v_rd_ff      <= 1'b0;
         v_sp_ff      <= 1'b0;
         v_in_ff      <= 1'b0;
         v_un_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         boxnum_ff    <= boxnum_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
         v_rd_ff      <= issue;
         v_sp_ff      <= v_rd_ff;
         v_in_ff      <= v_sp_ff;
         v_un_ff      <= v_in_ff;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

endmodule
